@@ hdl/mdt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mdt_pkg;

	localparam int DUTY_W  = 16;
	localparam int VOLT_W  = 16;
	localparam int CURR_W  = 16;
	localparam int POWER_W = 24;
	localparam int STEP_W  = 15;
	localparam int CFG_IDX_W = 3;

	typedef logic signed [1:0] dir_t;

	localparam dir_t DIR_DOWN = 2'sb11;
	localparam dir_t DIR_ZERO = 2'sb00;
	localparam dir_t DIR_UP   = 2'sb01;

	typedef logic [1:0] mode_t;

	localparam mode_t MODE_TRACK  = 2'd0;
	localparam mode_t MODE_SWEEP  = 2'd1;
	localparam mode_t MODE_SAMPLE = 2'd2;
	localparam mode_t MODE_PRESET = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CURR_LIM  = 3'd4;

	// Status returned by the conductance unit.
	typedef struct packed {
		logic done;
		dir_t dir;
	} ic_stat_t;

endpackage
`default_nettype wire

@@ hdl/mdt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface mdt_in_if;
	logic                valid;
	logic                ready;
	logic [1:0]          mode;
	logic [15:0]         voltage_mv;
	logic signed [15:0]  current_ma;
	logic [23:0]         power_mw;
	logic [15:0]         preset_duty;

	modport source (output valid, mode, voltage_mv, current_ma, power_mw, preset_duty,
		input ready);
	modport sink (input valid, mode, voltage_mv, current_ma, power_mw, preset_duty,
		output ready);
endinterface

interface mdt_out_if;
	logic                valid;
	logic                ready;
	logic [15:0]         duty_next;
	logic signed [1:0]   step_direction;
	logic                current_limited;
	logic                sweep_active;
	logic                sweep_done;

	modport source (output valid, duty_next, step_direction, current_limited, sweep_active,
		sweep_done, input ready);
	modport sink (input valid, duty_next, step_direction, current_limited, sweep_active,
		sweep_done, output ready);
endinterface
`default_nettype wire

@@ hdl/mdt_ic_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mdt_ic_unit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [15:0]             voltage_mv,
	input  wire logic signed [15:0]      current_ma,
	input  wire logic [15:0]             prev_voltage,
	input  wire logic signed [15:0]      prev_current,
	output mdt_pkg::ic_stat_t            stat
);
	import mdt_pkg::*;

	typedef enum logic [6:0] {
		IC_IDLE = 7'b0000001,
		IC_MUL1 = 7'b0000010,
		IC_MUL2 = 7'b0000100,
		IC_MUL3 = 7'b0001000,
		IC_ABS  = 7'b0010000,
		IC_K1   = 7'b0100000,
		IC_K2   = 7'b1000000
	} ic_state_t;

	ic_state_t state_q;

	logic signed [16:0] du_q;
	logic signed [16:0] di_q;
	logic [15:0]        v_q;
	logic signed [15:0] i_q;

	logic signed [16:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [33:0] mul_p;
	logic signed [33:0] prod_q;
	logic signed [34:0] acc_q;
	logic [34:0]        sabs_q;
	logic [33:0]        dabs_q;
	logic               sneg_q;
	logic               dneg_q;
	logic [45:0]        t_q;
	logic               done_q;
	dir_t               dir_dec;

	// One signed multiplier serves all three products.
	always_comb begin
		mul_a = di_q;
		mul_b = $signed({1'b0, v_q});
		case (state_q)
			IC_MUL1: begin
				mul_a = di_q;
				mul_b = $signed({1'b0, v_q});
			end
			IC_MUL2: begin
				mul_a = 17'(i_q);
				mul_b = du_q;
			end
			IC_MUL3: begin
				mul_a = du_q;
				mul_b = $signed({1'b0, v_q});
			end
			default: begin
				mul_a = di_q;
				mul_b = $signed({1'b0, v_q});
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// The tolerance test compares 1000*|S| against |D|, where S = dI*V + I*dU.
	always_comb begin
		if (du_q == '0) begin
			if (di_q == '0)
				dir_dec = DIR_ZERO;
			else if (!di_q[16])
				dir_dec = DIR_DOWN;
			else
				dir_dec = DIR_UP;
		end else if (v_q == '0) begin
			if (i_q == '0)
				dir_dec = DIR_ZERO;
			else if (!i_q[15])
				dir_dec = DIR_DOWN;
			else
				dir_dec = DIR_UP;
		end else if (t_q <= {12'b0, dabs_q}) begin
			dir_dec = DIR_ZERO;
		end else if (sneg_q == dneg_q) begin
			dir_dec = DIR_DOWN;
		end else begin
			dir_dec = DIR_UP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IC_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == IC_K2);
			case (state_q)
				IC_IDLE: if (start) state_q <= IC_MUL1;
				IC_MUL1: state_q <= IC_MUL2;
				IC_MUL2: state_q <= IC_MUL3;
				IC_MUL3: state_q <= IC_ABS;
				IC_ABS:  state_q <= IC_K1;
				IC_K1:   state_q <= IC_K2;
				IC_K2:   state_q <= IC_IDLE;
				default: state_q <= IC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IC_IDLE: begin
				if (start) begin
					du_q <= $signed({1'b0, voltage_mv}) - $signed({1'b0, prev_voltage});
					di_q <= 17'(current_ma) - 17'(prev_current);
					v_q  <= voltage_mv;
					i_q  <= current_ma;
				end
			end
			IC_MUL1: prod_q <= mul_p;
			IC_MUL2: begin
				prod_q <= mul_p;
				acc_q  <= 35'(prod_q);
			end
			IC_MUL3: begin
				prod_q <= mul_p;
				acc_q  <= acc_q + 35'(prod_q);
			end
			IC_ABS: begin
				sneg_q <= acc_q[34];
				dneg_q <= prod_q[33];
				sabs_q <= acc_q[34] ? 35'(-acc_q) : 35'(acc_q);
				dabs_q <= prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
			end
			IC_K1: t_q <= {1'b0, sabs_q, 10'b0} - {7'b0, sabs_q, 4'b0};
			IC_K2: begin
				t_q   <= t_q - {8'b0, sabs_q, 3'b0};
			end
			default: begin
			end
		endcase
	end

	// The decision reads t_q after the last subtraction, so it is taken from the
	// cycle in which done is raised.
	assign stat.done = done_q;
	assign stat.dir  = dir_dec;

	property p_done_after_k2;
		@(posedge clk) disable iff (!arst_n) done_q |-> $past(state_q == IC_K2);
	endproperty
	a_done_after_k2: assert property (p_done_after_k2) else $error("ic done out of sequence");

	property p_start_runs;
		@(posedge clk) disable iff (!arst_n) (state_q == IC_IDLE && start) |=> state_q == IC_MUL1;
	endproperty
	a_start_runs: assert property (p_start_runs) else $error("ic unit did not start");

	property p_done_idle;
		@(posedge clk) disable iff (!arst_n) done_q |-> state_q == IC_IDLE;
	endproperty
	a_done_idle: assert property (p_done_idle) else $error("ic unit busy after done");

endmodule
`default_nettype wire

@@ hdl/mppt_duty_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// MPPT duty-cycle tracker. Each input beat carries one measurement and a mode
// (track, sweep start, sweep sample, preset) and yields exactly one result beat.
// Sweep start, sweep sample and preset items go from acceptance straight to the result
// state; a track item passes the step and clamp states, with incremental conductance
// first waiting on the conductance unit, whose shared 17x17 multiplier and subtract
// chain for the x1000 tolerance run six sequencer steps. A result appears in the
// same cycle that ready returns, and the block waits in place if the previous result
// beat has not yet been taken. Configuration registers are written through cfg_we,
// cfg_index and cfg_data and must only change while no item is in flight.
module mppt_duty_tracker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [mdt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [15:0]                     cfg_data,
	mdt_in_if.sink                               in_ch,
	mdt_out_if.source                            out_ch
);
	import mdt_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_IC    = 5'b00010,
		ST_STEP  = 5'b00100,
		ST_CLAMP = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t state_q;

	// Configuration.
	logic               alg_q;
	logic [15:0]        low_q;
	logic [15:0]        high_q;
	logic [14:0]        step_q;
	logic signed [15:0] clim_q;

	// Tracker state.
	logic [15:0]        duty_now_q;
	logic [15:0]        prev_duty_q;
	logic [15:0]        prev_v_q;
	logic signed [15:0] prev_i_q;
	logic [23:0]        prev_p_q;
	logic               sweeping_q;
	logic [15:0]        pos_q;
	logic [23:0]        best_p_q;
	logic [15:0]        best_d_q;
	logic [15:0]        best_v_q;
	logic signed [15:0] best_i_q;

	// Latched item and work registers.
	mode_t              mode_q;
	logic [15:0]        v_q;
	logic signed [15:0] i_q;
	logic [23:0]        p_q;
	logic [15:0]        preset_q;
	dir_t               dir_q;
	logic               lim_q;
	logic signed [17:0] nd_q;
	logic [15:0]        clamp_q;

	// Result register.
	logic               out_vld_q;
	logic [15:0]        out_duty_q;
	dir_t               out_dir_q;
	logic               out_lim_q;
	logic               out_act_q;
	logic               out_done_q;

	logic               accept;
	logic               ic_start;
	ic_stat_t           ic_stat;
	dir_t               po_dir;
	logic               lim_now;
	dir_t               dir_eff;
	logic signed [17:0] nd_calc;
	logic               fire;
	logic               gain;
	logic [23:0]        nb_p;
	logic [15:0]        nb_d;
	logic [15:0]        nb_v;
	logic signed [15:0] nb_i;
	logic [16:0]        next_pos;
	logic [15:0]        res_duty;
	dir_t               res_dir;
	logic               res_lim;
	logic               res_act;
	logic               res_done;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign ic_start    = accept && (in_ch.mode == MODE_TRACK) && alg_q;

	mdt_ic_unit u_ic (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (ic_start),
		.voltage_mv   (in_ch.voltage_mv),
		.current_ma   (in_ch.current_ma),
		.prev_voltage (prev_v_q),
		.prev_current (prev_i_q),
		.stat         (ic_stat)
	);

	// Perturb and observe: keep going the way the duty last moved while power rises.
	always_comb begin
		if (in_ch.power_mw > prev_p_q)
			po_dir = (duty_now_q < prev_duty_q) ? DIR_DOWN : DIR_UP;
		else
			po_dir = (duty_now_q > prev_duty_q) ? DIR_DOWN : DIR_UP;
	end

	assign lim_now = (i_q >= clim_q);
	assign dir_eff = lim_now ? DIR_DOWN : dir_q;

	always_comb begin
		case (dir_eff)
			DIR_DOWN: nd_calc = $signed({2'b00, duty_now_q}) - $signed({3'b000, step_q});
			DIR_UP:   nd_calc = $signed({2'b00, duty_now_q}) + $signed({3'b000, step_q});
			default:  nd_calc = $signed({2'b00, duty_now_q});
		endcase
	end

	// Sweep sample bookkeeping: the candidate best and the next position.
	assign gain     = (p_q > best_p_q);
	assign nb_p     = gain ? p_q : best_p_q;
	assign nb_d     = gain ? pos_q : best_d_q;
	assign nb_v     = gain ? v_q : best_v_q;
	assign nb_i     = gain ? i_q : best_i_q;
	assign next_pos = {1'b0, pos_q} + {2'b00, step_q};

	assign fire = (state_q == ST_FIN) && (!out_vld_q || out_ch.ready);

	// Result fields for the item in hand.
	always_comb begin
		res_duty = duty_now_q;
		res_dir  = DIR_ZERO;
		res_lim  = 1'b0;
		res_act  = 1'b0;
		res_done = 1'b0;
		case (mode_q)
			MODE_TRACK: begin
				res_duty = clamp_q;
				res_dir  = dir_q;
				res_lim  = lim_q;
			end
			MODE_SWEEP: begin
				if (low_q > high_q) begin
					res_duty = '0;
					res_done = 1'b1;
				end else begin
					res_duty = low_q;
					res_act  = 1'b1;
				end
			end
			MODE_SAMPLE: begin
				if (sweeping_q) begin
					if (next_pos > {1'b0, high_q}) begin
						res_duty = nb_d;
						res_done = 1'b1;
					end else begin
						res_duty = next_pos[15:0];
						res_act  = 1'b1;
					end
				end
			end
			MODE_PRESET: res_duty = preset_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q  <= 1'b0;
			low_q  <= 16'd0;
			high_q <= 16'd255;
			step_q <= 15'd1;
			clim_q <= 16'sd32767;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ALGORITHM: alg_q  <= cfg_data[0];
				REG_DUTY_LOW:  low_q  <= cfg_data;
				REG_DUTY_HIGH: high_q <= cfg_data;
				REG_DUTY_STEP: step_q <= cfg_data[14:0];
				REG_CURR_LIM:  clim_q <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_ch.mode == MODE_TRACK)
							state_q <= alg_q ? ST_IC : ST_STEP;
						else
							state_q <= ST_FIN;
					end
				end
				ST_IC:    if (ic_stat.done) state_q <= ST_STEP;
				ST_STEP:  state_q <= ST_CLAMP;
				ST_CLAMP: state_q <= ST_FIN;
				ST_FIN:   if (fire) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_ch.mode;
			v_q      <= in_ch.voltage_mv;
			i_q      <= in_ch.current_ma;
			p_q      <= in_ch.power_mw;
			preset_q <= in_ch.preset_duty;
			dir_q    <= po_dir;
		end else if (state_q == ST_IC && ic_stat.done) begin
			dir_q <= ic_stat.dir;
		end else if (state_q == ST_STEP) begin
			dir_q <= dir_eff;
			lim_q <= lim_now;
			nd_q  <= nd_calc;
		end else if (state_q == ST_CLAMP) begin
			if (nd_q < $signed({2'b00, low_q}))
				clamp_q <= low_q;
			else if (nd_q > $signed({2'b00, high_q}))
				clamp_q <= high_q;
			else
				clamp_q <= nd_q[15:0];
		end
	end

	// State commit and result load happen together once the result slot is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_now_q  <= 16'd15;
			prev_duty_q <= 16'd15;
			prev_v_q    <= '0;
			prev_i_q    <= '0;
			prev_p_q    <= '0;
			sweeping_q  <= 1'b0;
			pos_q       <= '0;
			best_p_q    <= '0;
			best_d_q    <= '0;
			best_v_q    <= '0;
			best_i_q    <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (fire)
				out_vld_q <= 1'b1;
			else if (out_ch.ready)
				out_vld_q <= 1'b0;
			if (fire) begin
				out_duty_q <= res_duty;
				out_dir_q  <= res_dir;
				out_lim_q  <= res_lim;
				out_act_q  <= res_act;
				out_done_q <= res_done;
				case (mode_q)
					MODE_TRACK: begin
						sweeping_q  <= 1'b0;
						prev_v_q    <= v_q;
						prev_i_q    <= i_q;
						prev_p_q    <= p_q;
						prev_duty_q <= duty_now_q;
						duty_now_q  <= clamp_q;
					end
					MODE_SWEEP: begin
						best_p_q <= '0;
						best_d_q <= '0;
						best_v_q <= prev_v_q;
						best_i_q <= prev_i_q;
						if (low_q > high_q) begin
							// Empty range: the sweep ends at once on duty zero.
							sweeping_q  <= 1'b0;
							duty_now_q  <= '0;
							prev_duty_q <= '0;
						end else begin
							sweeping_q <= 1'b1;
							pos_q      <= low_q;
						end
					end
					MODE_SAMPLE: begin
						if (sweeping_q) begin
							best_p_q <= nb_p;
							best_d_q <= nb_d;
							best_v_q <= nb_v;
							best_i_q <= nb_i;
							if (next_pos > {1'b0, high_q}) begin
								sweeping_q  <= 1'b0;
								duty_now_q  <= nb_d;
								prev_duty_q <= nb_d;
								if (nb_p != '0) begin
									prev_p_q <= nb_p;
									prev_v_q <= nb_v;
									prev_i_q <= nb_i;
								end
							end else begin
								pos_q <= next_pos[15:0];
							end
						end
					end
					MODE_PRESET: begin
						sweeping_q  <= 1'b0;
						duty_now_q  <= preset_q;
						prev_duty_q <= preset_q;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_ch.valid           = out_vld_q;
	assign out_ch.duty_next       = out_duty_q;
	assign out_ch.step_direction  = out_dir_q;
	assign out_ch.current_limited = out_lim_q;
	assign out_ch.sweep_active    = out_act_q;
	assign out_ch.sweep_done      = out_done_q;

	property p_limited_down;
		@(posedge clk) disable iff (!arst_n)
			(out_vld_q && out_lim_q) |-> (out_dir_q == DIR_DOWN);
	endproperty
	a_limited_down: assert property (p_limited_down) else $error("limit without down step");

	property p_act_done_excl;
		@(posedge clk) disable iff (!arst_n) out_vld_q |-> !(out_act_q && out_done_q);
	endproperty
	a_act_done_excl: assert property (p_act_done_excl) else $error("sweep active and done");

	property p_hold_when_blocked;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_FIN && out_vld_q && !out_ch.ready) |=>
				($stable(duty_now_q) && state_q == ST_FIN);
	endproperty
	a_hold_when_blocked: assert property (p_hold_when_blocked) else $error("result overrun");

	property p_dir_only_track;
		@(posedge clk) disable iff (!arst_n)
			(out_vld_q && (out_act_q || out_done_q)) |-> (out_dir_q == DIR_ZERO);
	endproperty
	a_dir_only_track: assert property (p_dir_only_track) else $error("direction in sweep");

endmodule
`default_nettype wire
